// File: rtl/trmp_pkg.sv
// ----------------------------------------------------------------------------
// trmp_pkg
// Shared types and constants for the paired running median block.
// ----------------------------------------------------------------------------
package trmp_pkg;

	localparam int SAMPLE_W = 16;
	localparam int LIMIT_W  = 8;
	localparam int CFG_IDX_W = 2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_OPEN_THRESHOLD   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_OPEN_COUNT_LIMIT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_DOOR_WATCH_EN    = 2'd2;

	localparam logic signed [SAMPLE_W-1:0] OPEN_THRESHOLD_RST   = 16'sd1200;
	localparam logic [LIMIT_W-1:0]         OPEN_COUNT_LIMIT_RST = 8'd5;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] x_sample;
		logic signed [SAMPLE_W-1:0] y_sample;
	} in_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] median_x;
		logic signed [SAMPLE_W-1:0] median_y;
		logic                       median_valid;
		logic                       open_pulse;
	} out_t;

	// request from the top level to one axis sorter
	typedef struct packed {
		logic start;
		logic full;
	} axis_cmd_t;

	// status from one axis sorter back to the top level
	typedef struct packed {
		logic                       done;
		logic signed [SAMPLE_W-1:0] median;
	} axis_sts_t;

endpackage

// File: rtl/trimmed_running_median_pair.sv
// ----------------------------------------------------------------------------
// trimmed_running_median_pair
// Running median of x,y position samples with a door-open detector on x.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_stall carry one x,y sample per transaction; out_valid/
//   out_stall return exactly one result per sample, in order.
//   Each axis keeps a sorted window of WINDOW entries in a small memory and
//   walks it with one comparator, one entry per cycle. A replacement sample
//   first fetches the extremes and the median, then walks the window, reads
//   back the median and loads the result; a filling sample skips the fetch
//   and goes straight to the walk, the median readback and the result load.
//   in_stall is high while a sample is in work; the next sample is taken
//   as soon as the result is loaded, even if that result is still stalled.
//   If out_stall holds a finished result, the next one waits in the block.
//   Until WINDOW samples have arrived median_valid is 0 and the medians 0.
//   Reset empties the window, clears the door counter and loads the
//   register defaults (threshold 1200, limit 5, watching off).
//   Configuration is written through cfg_we/cfg_index/cfg_data while idle.
// ----------------------------------------------------------------------------
module trimmed_running_median_pair #(
	parameter int WINDOW = 20
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_stall,
	input  trmp_pkg::in_t                          in_data,
	output logic                                   out_valid,
	input  logic                                   out_stall,
	output trmp_pkg::out_t                         out_data,
	input  logic                                   cfg_we,
	input  logic [trmp_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [trmp_pkg::SAMPLE_W-1:0]          cfg_data
);
	import trmp_pkg::*;

	localparam int CW = $clog2(WINDOW+1);
	localparam logic T_IDLE = 1'b0;
	localparam logic T_RUN  = 1'b1;

	logic                       state_q;
	logic [CW-1:0]              fill_q;
	logic [LIMIT_W-1:0]         open_cnt_q;
	logic signed [SAMPLE_W-1:0] thr_q;
	logic [LIMIT_W-1:0]         limit_q;
	logic                       watch_q;
	logic                       valid_after_q, door_q;
	logic                       dx_q, dy_q;
	logic signed [SAMPLE_W-1:0] mx_q, my_q;
	logic                       out_valid_q;
	out_t                       out_q;

	logic          accept, full, load;
	logic [LIMIT_W-1:0] cnt_next;
	axis_cmd_t     cmd;
	axis_sts_t     sts_x, sts_y;

	assign accept = in_valid && !in_stall;
	assign full   = (fill_q == CW'(WINDOW));
	assign load   = (state_q == T_RUN) && dx_q && dy_q && (!out_valid_q || !out_stall);

	assign cmd.start = accept;
	assign cmd.full  = full;

	assign cnt_next = (watch_q && in_data.x_sample > thr_q) ? open_cnt_q + LIMIT_W'(1)
	                                                         : open_cnt_q;

	trmp_axis #(.WINDOW(WINDOW)) u_axis_x (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.count  (fill_q),
		.sample (in_data.x_sample),
		.sts    (sts_x)
	);

	trmp_axis #(.WINDOW(WINDOW)) u_axis_y (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.count  (fill_q),
		.sample (in_data.y_sample),
		.sts    (sts_y)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q   <= OPEN_THRESHOLD_RST;
			limit_q <= OPEN_COUNT_LIMIT_RST;
			watch_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_OPEN_THRESHOLD:   thr_q   <= cfg_data;
				CFG_OPEN_COUNT_LIMIT: limit_q <= cfg_data[LIMIT_W-1:0];
				CFG_DOOR_WATCH_EN:    watch_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= T_IDLE;
			fill_q        <= '0;
			open_cnt_q    <= '0;
			valid_after_q <= 1'b0;
			door_q        <= 1'b0;
			dx_q          <= 1'b0;
			dy_q          <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			if (accept) begin
				state_q <= T_RUN;
				dx_q    <= 1'b0;
				dy_q    <= 1'b0;
				if (full) begin
					valid_after_q <= 1'b1;
					// counting only on replacement samples
					if (cnt_next >= limit_q) begin
						door_q     <= 1'b1;
						open_cnt_q <= '0;
					end else begin
						door_q     <= 1'b0;
						open_cnt_q <= cnt_next;
					end
				end else begin
					fill_q        <= fill_q + CW'(1);
					valid_after_q <= (fill_q == CW'(WINDOW - 1));
					door_q        <= 1'b0;
				end
			end else begin
				if (sts_x.done) begin
					dx_q <= 1'b1;
				end
				if (sts_y.done) begin
					dy_q <= 1'b1;
				end
				if (load) begin
					state_q <= T_IDLE;
					dx_q    <= 1'b0;
					dy_q    <= 1'b0;
				end
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (sts_x.done) begin
			mx_q <= sts_x.median;
		end
		if (sts_y.done) begin
			my_q <= sts_y.median;
		end
		if (load) begin
			out_q.median_x     <= valid_after_q ? mx_q : '0;
			out_q.median_y     <= valid_after_q ? my_q : '0;
			out_q.median_valid <= valid_after_q;
			out_q.open_pulse   <= door_q;
		end
	end

	assign in_stall  = (state_q == T_RUN);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

// File: rtl/trmp_axis.sv
// ----------------------------------------------------------------------------
// trmp_axis
// Sorted window of one axis: inserts a sample in order, or replaces the
// extreme on the wider side once full, then reads back the median entry.
// ----------------------------------------------------------------------------
module trmp_axis #(
	parameter int WINDOW = 20
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  trmp_pkg::axis_cmd_t                   cmd,
	input  logic [$clog2(WINDOW+1)-1:0]           count,
	input  logic signed [trmp_pkg::SAMPLE_W-1:0]  sample,
	output trmp_pkg::axis_sts_t                   sts
);
	import trmp_pkg::*;

	localparam int AW = $clog2(WINDOW);
	localparam int CW = $clog2(WINDOW+1);
	localparam logic [AW-1:0] TOP_IDX = AW'(WINDOW - 1);
	localparam logic [AW-1:0] MED_IDX = AW'(WINDOW / 2);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_LD0  = 4'd1;
	localparam logic [3:0] S_LD1  = 4'd2;
	localparam logic [3:0] S_LD2  = 4'd3;
	localparam logic [3:0] S_DEC  = 4'd4;
	localparam logic [3:0] S_DN   = 4'd5;
	localparam logic [3:0] S_UP   = 4'd6;
	localparam logic [3:0] S_MRD  = 4'd7;
	localparam logic [3:0] S_MCAP = 4'd8;

	logic [3:0] state_q, state_d;
	logic [AW-1:0] idx_q, idx_d;
	logic signed [SAMPLE_W-1:0] val_q, min_q, max_q;
	logic signed [SAMPLE_W-1:0] win_mem [WINDOW];
	logic signed [SAMPLE_W-1:0] rd_q;

	logic                       we, re;
	logic [AW-1:0]              wa, ra;
	logic signed [SAMPLE_W-1:0] wd;
	logic signed [SAMPLE_W:0]   upper, lower;
	logic [AW:0]                idx_p2;

	always_ff @(posedge clk) begin
		if (we) begin
			win_mem[wa] <= wd;
		end
		if (re) begin
			rd_q <= win_mem[ra];
		end
	end

	// rd_q holds the median in the decision state
	assign upper  = {max_q[SAMPLE_W-1], max_q} - {rd_q[SAMPLE_W-1], rd_q};
	assign lower  = {rd_q[SAMPLE_W-1], rd_q} - {min_q[SAMPLE_W-1], min_q};
	assign idx_p2 = {1'b0, idx_q} + (AW+1)'(2);

	always_comb begin
		state_d = state_q;
		idx_d   = idx_q;
		we      = 1'b0;
		wa      = idx_q;
		wd      = val_q;
		re      = 1'b0;
		ra      = '0;
		case (state_q)
			S_IDLE: begin
				if (cmd.start) begin
					if (cmd.full) begin
						state_d = S_LD0;
					end else begin
						idx_d   = count[AW-1:0];
						re      = (count != '0);
						ra      = AW'(count - CW'(1));
						state_d = S_DN;
					end
				end
			end
			S_LD0: begin
				re      = 1'b1;
				ra      = '0;
				state_d = S_LD1;
			end
			S_LD1: begin
				re      = 1'b1;
				ra      = TOP_IDX;
				state_d = S_LD2;
			end
			S_LD2: begin
				re      = 1'b1;
				ra      = MED_IDX;
				state_d = S_DEC;
			end
			S_DEC: begin
				re = 1'b1;
				if (upper > lower) begin
					// drop the max, walk down from the top slot
					idx_d   = TOP_IDX;
					ra      = TOP_IDX - AW'(1);
					state_d = S_DN;
				end else begin
					// drop the min, walk up from the bottom slot
					idx_d   = '0;
					ra      = AW'(1);
					state_d = S_UP;
				end
			end
			S_DN: begin
				// rd_q holds entry idx-1, entry idx-2 is being fetched
				we = 1'b1;
				wa = idx_q;
				if (idx_q != '0 && rd_q > val_q) begin
					wd    = rd_q;
					idx_d = idx_q - AW'(1);
					re    = (idx_q >= AW'(2));
					ra    = idx_q - AW'(2);
				end else begin
					wd      = val_q;
					state_d = S_MRD;
				end
			end
			S_UP: begin
				// rd_q holds entry idx+1, equal entries stay below the new one
				we = 1'b1;
				wa = idx_q;
				if (idx_q != TOP_IDX && rd_q <= val_q) begin
					wd    = rd_q;
					idx_d = idx_q + AW'(1);
					re    = (idx_p2 < (AW+1)'(WINDOW));
					ra    = idx_p2[AW-1:0];
				end else begin
					wd      = val_q;
					state_d = S_MRD;
				end
			end
			S_MRD: begin
				re      = 1'b1;
				ra      = MED_IDX;
				state_d = S_MCAP;
			end
			S_MCAP: begin
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			idx_q   <= '0;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
		end
	end

	// the bottom entry arrives in LD1, the top entry in LD2
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && cmd.start) begin
			val_q <= sample;
		end
		if (state_q == S_LD1) begin
			min_q <= rd_q;
		end
		if (state_q == S_LD2) begin
			max_q <= rd_q;
		end
	end

	assign sts.done   = (state_q == S_MCAP);
	assign sts.median = rd_q;

endmodule

// File: rtl/trmp_checker.sv
// ----------------------------------------------------------------------------
// trmp_checker
// Port-level checks for the paired running median block.
// ----------------------------------------------------------------------------
module trmp_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           in_valid,
	input logic           in_stall,
	input trmp_pkg::in_t  in_data,
	input logic           out_valid,
	input logic           out_stall,
	input trmp_pkg::out_t out_data
);
	import trmp_pkg::*;

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("stalled result changed");

	// one sample in work at a time
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("new sample taken while busy");

	// while filling, medians and door flag are zero
	a_fill_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.median_valid |->
			out_data.median_x == 16'sd0 && out_data.median_y == 16'sd0 &&
			!out_data.open_pulse)
		else $error("nonzero result while window filling");

	// once the window is full it stays full
	a_valid_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.median_valid |=> !out_valid || out_data.median_valid)
		else $error("median_valid dropped");

endmodule

bind trimmed_running_median_pair trmp_checker u_trmp_checker (.*);

// File: tb/sv/tb_trimmed_running_median_pair.sv
// ----------------------------------------------------------------------------
// tb_trimmed_running_median_pair
// Self-checking bench for the paired running median and door-open detector.
// Samples go in over a valid/stall channel with random gaps while the result
// side stalls at random. A scoreboard keeps its own sorted x and y windows and
// door counter, predicts each result and checks it field by field. The run
// covers the window fill, extreme and tied samples, and several register
// settings including the threshold extremes and the count limits 0, 1 and 255.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_trimmed_running_median_pair;
	import trmp_pkg::*;

	localparam int WINDOW         = 20;
	localparam int DRAIN_CYCLES   = 2 * (WINDOW + 7);
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DIRECTED_COUNT = 25;

	// window fill with extremes and ties, then a few replacement samples
	localparam int DIRECTED_X [DIRECTED_COUNT] = '{
		-32768, 32767, 0, -1, 1, 5, 5, 5, 1200, 1201,
		1199, -100, 100, 32767, -32768, 7, 7, 300, -300, 42,
		1200, 1201, 32767, -32768, 0
	};
	localparam int DIRECTED_Y [DIRECTED_COUNT] = '{
		32767, -32768, -1, 0, 5, 5, 5, -5, -5, 0,
		-32768, 32767, 3, 3, 3, -2, 900, -900, 12, -12,
		0, 0, -32768, 32767, 5
	};

	typedef logic signed [SAMPLE_W-1:0] sample_t;

	class median_pair_scoreboard;
		sample_t           win [2][WINDOW];
		int                filled;
		logic [LIMIT_W-1:0] open_count;
		sample_t           threshold;
		logic [LIMIT_W-1:0] count_limit;
		bit                watch_en;
		out_t              pending_medians[$];
		int                errors;

		function new();
			filled      = 0;
			open_count  = '0;
			threshold   = OPEN_THRESHOLD_RST;
			count_limit = OPEN_COUNT_LIMIT_RST;
			watch_en    = 1'b0;
			errors      = 0;
		endfunction

		function void set_register(logic [CFG_IDX_W-1:0] idx, logic [SAMPLE_W-1:0] val);
			case (idx)
				CFG_OPEN_THRESHOLD:   threshold = val;
				CFG_OPEN_COUNT_LIMIT: count_limit = val[LIMIT_W-1:0];
				CFG_DOOR_WATCH_EN:    watch_en = val[0];
				default: ;
			endcase
		endfunction

		// equal entries stay ahead of the new value
		function void insert_in_order(int axis, int n, sample_t v);
			int i;
			i = n;
			while (i > 0 && win[axis][i-1] > v) begin
				win[axis][i] = win[axis][i-1];
				i--;
			end
			win[axis][i] = v;
		endfunction

		function void replace_extreme(int axis, sample_t v);
			logic signed [SAMPLE_W:0] upper;
			logic signed [SAMPLE_W:0] lower;
			upper = win[axis][WINDOW-1] - win[axis][WINDOW/2];
			lower = win[axis][WINDOW/2] - win[axis][0];
			// drop the minimum unless the top spread is strictly wider
			if (!(upper > lower)) begin
				for (int i = 0; i < WINDOW - 1; i++)
					win[axis][i] = win[axis][i+1];
			end
			insert_in_order(axis, WINDOW - 1, v);
		endfunction

		function void note_sample(in_t s);
			out_t    want;
			sample_t x;
			sample_t y;
			want = '0;
			x = s.x_sample;
			y = s.y_sample;
			if (filled < WINDOW) begin
				insert_in_order(0, filled, x);
				insert_in_order(1, filled, y);
				filled++;
			end else begin
				replace_extreme(0, x);
				replace_extreme(1, y);
				if (watch_en && x > threshold)
					open_count = open_count + 1'b1;
				if (open_count >= count_limit) begin
					want.open_pulse = 1'b1;
					open_count = '0;
				end
			end
			if (filled >= WINDOW) begin
				want.median_valid = 1'b1;
				want.median_x = win[0][WINDOW/2];
				want.median_y = win[1][WINDOW/2];
			end
			pending_medians.push_back(want);
		endfunction

		function void compare_field(string name, logic signed [31:0] want,
				logic signed [31:0] got);
			if (want !== got) begin
				$display("%0t: %s mismatch: expected %0d, actual %0d",
					$time, name, want, got);
				errors++;
			end
		endfunction

		function void check_median(out_t got);
			out_t want;
			if (pending_medians.size() == 0) begin
				$display({"%0t: result with none expected: expected none, ",
					"actual x=%0d y=%0d valid=%0b door=%0b"},
					$time, got.median_x, got.median_y, got.median_valid,
					got.open_pulse);
				errors++;
				return;
			end
			want = pending_medians.pop_front();
			compare_field("median_x", want.median_x, got.median_x);
			compare_field("median_y", want.median_y, got.median_y);
			compare_field("median_valid", want.median_valid, got.median_valid);
			compare_field("open_pulse", want.open_pulse, got.open_pulse);
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_stall;
	in_t                   in_data;
	logic                  out_valid;
	logic                  out_stall;
	out_t                  out_data;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [SAMPLE_W-1:0]   cfg_data;

	median_pair_scoreboard board;
	bit                    idle_on;
	int                    quiet_cycles;

	trimmed_running_median_pair #(
		.WINDOW(WINDOW)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		if (out_valid && !out_stall)
			board.check_median(out_data);
	end

	// receiver stalls in random bursts
	initial begin
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (idle_on && $urandom_range(0, 4) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 11)) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("Regression FAIL");
				$finish;
			end
		end
	end

	// called right after a rising edge, returns right after the accepting edge
	task automatic send_sample(input in_t s);
		if (idle_on && $urandom_range(0, 2) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= s;
		do @(posedge clk); while (in_stall);
		board.note_sample(s);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (board.pending_medians.size() != 0) @(posedge clk);
	endtask

	// leaves the write enable high, the caller drops it after the last write
	task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
			input logic [SAMPLE_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		board.set_register(idx, val);
	endtask

	task automatic apply_settings(input int thr, input int limit, input bit watch);
		write_register(CFG_OPEN_THRESHOLD, thr[SAMPLE_W-1:0]);
		write_register(CFG_OPEN_COUNT_LIMIT, SAMPLE_W'(limit));
		write_register(CFG_DOOR_WATCH_EN, SAMPLE_W'(watch));
		cfg_we <= 1'b0;
	endtask

	// mix of full-range values, extremes, values near a centre and a tight
	// cluster that produces ties and equal spreads
	function automatic sample_t pick_sample(int centre);
		int v;
		case ($urandom_range(0, 9))
			0:       v = int'($urandom_range(0, 65535)) - 32768;
			1:       v = $urandom_range(0, 1) ? 32767 : -32768;
			2, 3, 4: v = centre + int'($urandom_range(0, 40)) - 20;
			default: v = int'($urandom_range(0, 100)) - 50;
		endcase
		if (v > 32767)
			v = 32767;
		if (v < -32768)
			v = -32768;
		return sample_t'(v);
	endfunction

	task automatic run_phase(input int count, input int centre);
		in_t s;
		repeat (count) begin
			s.x_sample = pick_sample(centre);
			s.y_sample = pick_sample(-centre);
			send_sample(s);
		end
	endtask

	initial begin
		in_t s;
		int  thr;
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		in_data   = '0;
		cfg_we    = 1'b0;
		cfg_index = CFG_OPEN_THRESHOLD;
		cfg_data  = '0;
		idle_on   = 1'b1;
		board     = new();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: watching off, so no door pulse while the limit is 5
		for (int i = 0; i < DIRECTED_COUNT; i++) begin
			s.x_sample = sample_t'(DIRECTED_X[i]);
			s.y_sample = sample_t'(DIRECTED_Y[i]);
			send_sample(s);
		end
		wait_drained();

		apply_settings(1200, 5, 1'b1);
		run_phase(220, 1200);
		wait_drained();

		// nearly every x counts, pulse on every counted sample
		apply_settings(-32768, 1, 1'b1);
		run_phase(220, -32768);
		wait_drained();

		// nothing can exceed the top threshold
		apply_settings(32767, 255, 1'b1);
		run_phase(220, 32767);
		wait_drained();

		// limit zero pulses on every replacement even with watching off
		thr = int'($urandom_range(0, 65535)) - 32768;
		apply_settings(thr, 0, 1'b0);
		run_phase(220, thr);
		wait_drained();

		// long enough to walk the counter up to the largest limit
		apply_settings(-1000, 255, 1'b1);
		run_phase(300, 0);
		wait_drained();

		thr = int'($urandom_range(0, 4000)) - 2000;
		apply_settings(thr, $urandom_range(1, 8), 1'b1);
		idle_on = 1'b0;
		run_phase(240, thr);
		wait_drained();

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (board.errors == 0 && board.pending_medians.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

// File: sim.f
rtl/trmp_pkg.sv
rtl/trmp_axis.sv
rtl/trimmed_running_median_pair.sv
rtl/trmp_checker.sv
tb/sv/tb_trimmed_running_median_pair.sv
